// ===== hdl/iou_pkg.sv =====
// Package for the IoU track id assigner: payload word types and shared constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package iou_pkg;
  localparam int unsigned CoordBits = 12;
  localparam int unsigned SizeBits  = CoordBits - 1;
  localparam int unsigned IdBits    = 32;
  localparam int unsigned BoxBits   = 2 * CoordBits + 2 * SizeBits;
  localparam int unsigned AreaBits  = 2 * CoordBits;
  localparam logic [7:0]  ThrReset  = 8'd128;

  typedef enum logic {
    OP_DET = 1'b0,
    OP_EOF = 1'b1
  } op_t;

  typedef struct packed {
    op_t                        op;
    logic signed [CoordBits-1:0] box_left;
    logic signed [CoordBits-1:0] box_top;
    logic [SizeBits-1:0]        box_width;
    logic [SizeBits-1:0]        box_height;
  } in_word_t;

  typedef struct packed {
    logic [IdBits-1:0] track_id;
    logic              is_new;
    logic              dropped;
  } out_word_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] x;
    logic signed [CoordBits-1:0] y;
    logic [SizeBits-1:0]        w;
    logic [SizeBits-1:0]        h;
  } box_t;
endpackage
`default_nettype wire

// ===== hdl/iou_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module iou_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0]      rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

// ===== hdl/iou_overlap.sv =====
// Two-stage intersection/union unit for one stored box against the detection.
// Depends on iou_pkg.
`timescale 1ns / 1ps
`default_nettype none
module iou_overlap
  import iou_pkg::*;
(
  input  wire logic                clk,
  input  wire box_t                trk,
  input  wire box_t                det,
  output logic [AreaBits-1:0]      inter_r,
  output logic [AreaBits+1:0]      uni_r
);
  localparam int unsigned EB = CoordBits + 1;
  logic signed [EB:0]      ax1, bx1, ay1, by1, x0, y0, x1, y1, iw, ih;
  logic [SizeBits-1:0]     iw_r, ih_r;
  logic [AreaBits-1:0]     area_a_r, area_b_r;
  logic [AreaBits-1:0]     inter;
  logic [AreaBits+1:0]     uni;

  always_comb begin
    ax1 = (EB+1)'(trk.x) + $signed({2'b0, trk.w});
    bx1 = (EB+1)'(det.x) + $signed({2'b0, det.w});
    ay1 = (EB+1)'(trk.y) + $signed({2'b0, trk.h});
    by1 = (EB+1)'(det.y) + $signed({2'b0, det.h});
    x0  = (trk.x > det.x) ? (EB+1)'(trk.x) : (EB+1)'(det.x);
    y0  = (trk.y > det.y) ? (EB+1)'(trk.y) : (EB+1)'(det.y);
    x1  = (ax1 < bx1) ? ax1 : bx1;
    y1  = (ay1 < by1) ? ay1 : by1;
    iw  = x1 - x0;
    ih  = y1 - y0;
  end

  // Stage 1: clamp widths and form both box areas.
  always_ff @(posedge clk) begin
    iw_r     <= iw[EB] ? '0 : iw[SizeBits-1:0];
    ih_r     <= ih[EB] ? '0 : ih[SizeBits-1:0];
    area_a_r <= AreaBits'(trk.w) * AreaBits'(trk.h);
    area_b_r <= AreaBits'(det.w) * AreaBits'(det.h);
  end

  // Stage 2: intersection and union; zero union reads as 0 / 1.
  always_comb begin
    inter = AreaBits'(iw_r) * AreaBits'(ih_r);
    uni   = (AreaBits+2)'(area_a_r) + (AreaBits+2)'(area_b_r) - (AreaBits+2)'(inter);
  end

  always_ff @(posedge clk) begin
    if (uni == '0) begin
      inter_r <= '0;
      uni_r   <= (AreaBits+2)'(1);
    end else begin
      inter_r <= inter;
      uni_r   <= uni;
    end
  end
endmodule
`default_nettype wire

// ===== hdl/iou_track_id_assigner.sv =====
// Top level of the IoU track id assigner: sequencer, two ping-pong track tables.
// Depends on iou_pkg, iou_ram and iou_overlap.
//
//  channel | direction | handshake          | word
//  in_     | input     | in_valid/in_stall  | in_word_t  (op, box)
//  out_    | output    | out_valid/out_stall| out_word_t (id, is_new, dropped)
//  cfg_    | input     | cfg_wr_en          | 8-bit IoU threshold
//
// A detection reads each previous track, runs it through the overlap pipe and compares it
// before the next read issues, then searches the stored next-frame tracks one entry at a
// time for the id, stopping at a hit.
// End of frame flips a bank select; nothing is copied.
// rst_n (synchronous) clears counts, id counter and bank select and sets the threshold to ThrReset.
// The output register lets a new word in while a result waits; a stalled result holds.
`timescale 1ns / 1ps
`default_nettype none
module iou_track_id_assigner
  import iou_pkg::*;
#(
  parameter int unsigned MAX_TRACKS = 64
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire in_word_t   in_word,
  output logic            out_valid,
  input  wire logic       out_stall,
  output out_word_t       out_word,
  input  wire logic       cfg_wr_en,
  input  wire logic [7:0] cfg_wr_data
);
  localparam int unsigned AW = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int unsigned CW = $clog2(MAX_TRACKS + 1);
  localparam int unsigned EW = IdBits + BoxBits;
  localparam int unsigned PW = AreaBits + AreaBits + 2;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DRAIN, S_DECIDE, S_SRCH, S_WRITE, S_OUT
  } state_t;

  state_t           state_r;
  logic             bank_r;          // bank holding the previous frame
  logic [CW-1:0]    cnt_prev_r, cnt_next_r;
  logic [IdBits-1:0] id_ctr_r;
  logic [7:0]       thr_r;
  box_t             det_r;
  logic [CW-1:0]    rd_idx_r;
  logic [2:0]       vld_r;           // tags of the read / overlap pipe
  logic [IdBits-1:0] id_p1_r, id_p2_r;
  logic             have_r;
  logic [AreaBits-1:0] bi_r;
  logic [AreaBits+1:0] bu_r;
  logic [IdBits-1:0] bid_r;
  logic [IdBits-1:0] id_r;
  logic             new_r;
  logic             drop_r;
  logic [CW-1:0]    hit_r;
  logic             hit_v_r;
  logic             srch_v_r;
  logic [AW-1:0]    srch_a_r;
  logic             out_valid_r;
  out_word_t        out_word_r;

  // Two memories, one per bank; each holds {id, box}.
  logic [AW-1:0]    rd_addr;
  logic [EW-1:0]    rd0, rd1, rd_prev, rd_next;
  logic             we0, we1;
  logic [AW-1:0]    wr_addr;
  logic [EW-1:0]    wr_data;

  iou_ram #(.WIDTH(EW), .DEPTH(MAX_TRACKS)) u_bank0 (
    .clk(clk), .wr_en(we0), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_addr(rd_addr), .rd_data(rd0));
  iou_ram #(.WIDTH(EW), .DEPTH(MAX_TRACKS)) u_bank1 (
    .clk(clk), .wr_en(we1), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_addr(rd_addr), .rd_data(rd1));

  assign rd_prev = bank_r ? rd1 : rd0;
  assign rd_next = bank_r ? rd0 : rd1;

  logic [AreaBits-1:0] ov_i;
  logic [AreaBits+1:0] ov_u;
  iou_overlap u_ov (
    .clk(clk), .trk(box_t'(rd_prev[BoxBits-1:0])), .det(det_r),
    .inter_r(ov_i), .uni_r(ov_u));

  // Cross products of candidate against best, registered before the compare.
  logic [PW-1:0] lhs_r, rhs_r;
  logic [AreaBits-1:0] ci_r;
  logic [AreaBits+1:0] cu_r;
  logic [IdBits-1:0] cid_r;
  logic cv_r;

  logic accept_in, out_free, win;
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign accept_in = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  assign win = !have_r || (lhs_r > rhs_r) || ((lhs_r == rhs_r) && (cid_r < bid_r));

  logic [PW-1:0] m_l, m_r;
  assign m_l   = PW'({bi_r, 8'd0});
  assign m_r   = PW'(thr_r) * PW'(bu_r);

  always_comb begin
    rd_addr = rd_idx_r[AW-1:0];
    if (state_r == S_SRCH) begin
      rd_addr = srch_a_r;
    end
    we0 = 1'b0;
    we1 = 1'b0;
    wr_addr = hit_v_r ? hit_r[AW-1:0] : cnt_next_r[AW-1:0];
    wr_data = {id_r, det_r};
    if (state_r == S_WRITE && (hit_v_r || cnt_next_r < CW'(MAX_TRACKS))) begin
      we0 = bank_r;
      we1 = !bank_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bank_r      <= 1'b0;
      cnt_prev_r  <= '0;
      cnt_next_r  <= '0;
      id_ctr_r    <= '0;
      thr_r       <= ThrReset;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
      cv_r        <= 1'b0;
      srch_v_r    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        thr_r <= cfg_wr_data;
      end
      // Raise valid when a word is loaded, drop it once the receiver takes it.
      if (state_r == S_OUT && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      // Read / overlap pipe: address, RAM, overlap stage 1, overlap stage 2.
      id_p1_r <= rd_prev[EW-1:BoxBits];
      id_p2_r <= id_p1_r;
      vld_r   <= {vld_r[1:0], (state_r == S_SCAN) && (rd_idx_r < cnt_prev_r)};
      // vld_r[0]: RAM data valid; [2]: overlap output valid
      cv_r  <= vld_r[2] && (ov_i != '0);
      ci_r  <= ov_i;
      cu_r  <= ov_u;
      cid_r <= id_p2_r;
      lhs_r <= PW'(ov_i) * PW'(bu_r);
      rhs_r <= PW'(bi_r) * PW'(ov_u);
      if (cv_r && win) begin
        have_r <= 1'b1;
        bi_r   <= ci_r;
        bu_r   <= cu_r;
        bid_r  <= cid_r;
      end
      case (state_r)
        S_IDLE: begin
          if (accept_in) begin
            if (in_word.op == OP_EOF) begin
              bank_r     <= !bank_r;
              cnt_prev_r <= cnt_next_r;
              cnt_next_r <= '0;
            end else begin
              det_r    <= box_t'({in_word.box_left, in_word.box_top,
                                  in_word.box_width, in_word.box_height});
              rd_idx_r <= '0;
              have_r   <= 1'b0;
              bi_r     <= '0;
              bu_r     <= (AreaBits+2)'(1);
              state_r  <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // One read per cycle would overlap compares with the best update,
          // so issue the next read only once the previous compare has landed.
          if (rd_idx_r >= cnt_prev_r) begin
            rd_idx_r <= '0;
            state_r  <= S_DRAIN;
          end else begin
            rd_idx_r <= rd_idx_r + CW'(1);
            state_r  <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          // Wait for the pipe and the compare of the last issued read.
          if (vld_r == '0 && !cv_r) begin
            if (rd_idx_r == '0 || rd_idx_r >= cnt_prev_r) begin
              if (rd_idx_r >= cnt_prev_r || cnt_prev_r == '0) begin
                state_r <= S_DECIDE;
              end else begin
                state_r <= S_SCAN;
              end
            end else begin
              state_r <= S_SCAN;
            end
          end
        end
        S_DECIDE: begin
          if (have_r && (m_l > m_r)) begin
            id_r  <= bid_r;
            new_r <= 1'b0;
          end else begin
            id_r     <= id_ctr_r;
            new_r    <= 1'b1;
            id_ctr_r <= id_ctr_r + IdBits'(1);
          end
          hit_v_r  <= 1'b0;
          rd_idx_r <= '0;
          srch_a_r <= '0;
          srch_v_r <= 1'b0;
          state_r  <= (cnt_next_r == '0) ? S_WRITE : S_SRCH;
        end
        S_SRCH: begin
          // Read one next-frame entry, compare on the following cycle.
          if (srch_v_r) begin
            srch_v_r <= 1'b0;
            if (rd_next[EW-1:BoxBits] == id_r) begin
              hit_v_r <= 1'b1;
              hit_r   <= rd_idx_r;
              state_r <= S_WRITE;
            end else if (rd_idx_r + CW'(1) >= cnt_next_r) begin
              state_r <= S_WRITE;
            end else begin
              rd_idx_r <= rd_idx_r + CW'(1);
              srch_a_r <= AW'(rd_idx_r + CW'(1));
            end
          end else begin
            srch_v_r <= 1'b1;
          end
        end
        S_WRITE: begin
          if (!hit_v_r && cnt_next_r < CW'(MAX_TRACKS)) begin
            cnt_next_r <= cnt_next_r + CW'(1);
          end
          drop_r  <= !hit_v_r && (cnt_next_r >= CW'(MAX_TRACKS));
          state_r <= S_OUT;
        end
        S_OUT: begin
          // Load the result only once the output register is free.
          if (out_free) begin
            out_word_r.track_id <= id_r;
            out_word_r.is_new   <= new_r;
            out_word_r.dropped  <= drop_r;
            state_r             <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_next_r <= CW'(MAX_TRACKS))
    else $error("next count above capacity");
  a_no_in_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall)
    else $error("input taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_word)))
    else $error("stalled result changed");
  a_single_we: assert property (@(posedge clk) disable iff (!rst_n)
    !(we0 && we1))
    else $error("both banks written");
`endif
endmodule
`default_nettype wire

// ===== tb/iou_checker.sv =====
// Checker for the IoU track id assigner: watches both channels and the threshold port,
// predicts each result word and compares it. Depends on iou_pkg.
`timescale 1ns / 1ps
module iou_checker
  import iou_pkg::*;
#(
  parameter int unsigned MAX_TRACKS = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  in_word_t   in_word,
  input  logic       out_valid,
  input  logic       out_stall,
  input  out_word_t  out_word,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  output int         fail_count,
  output int         pending,
  output int         matched_count,
  output int         dropped_count
);
  logic [7:0]        thr;
  logic [IdBits-1:0] old_ids[MAX_TRACKS];
  box_t              old_boxes[MAX_TRACKS];
  int                old_cnt;
  logic [IdBits-1:0] cur_ids[MAX_TRACKS];
  box_t              cur_boxes[MAX_TRACKS];
  int                cur_cnt;
  logic [IdBits-1:0] next_id;
  out_word_t         expected_ids[$];

  // Intersection and union areas; a zero union is reported as 0 / 1.
  function automatic void box_overlap(input box_t a, input box_t b,
                                      output longint inter, output longint uni);
    longint x0, y0, x1, y1, iw, ih, ax1, bx1, ay1, by1;
    ax1 = longint'(a.x) + longint'(a.w);
    bx1 = longint'(b.x) + longint'(b.w);
    ay1 = longint'(a.y) + longint'(a.h);
    by1 = longint'(b.y) + longint'(b.h);
    x0 = (longint'(a.x) > longint'(b.x)) ? longint'(a.x) : longint'(b.x);
    y0 = (longint'(a.y) > longint'(b.y)) ? longint'(a.y) : longint'(b.y);
    x1 = (ax1 < bx1) ? ax1 : bx1;
    y1 = (ay1 < by1) ? ay1 : by1;
    iw = (x1 - x0 < 0) ? 0 : x1 - x0;
    ih = (y1 - y0 < 0) ? 0 : y1 - y0;
    inter = iw * ih;
    uni = longint'(a.w) * longint'(a.h) + longint'(b.w) * longint'(b.h) - inter;
    if (uni == 0) begin
      inter = 0;
      uni = 1;
    end
  endfunction

  // Greedy best-IoU match, then store under the id in the table being built.
  function automatic out_word_t assign_track(input box_t d);
    longint bi, bu, i, u;
    logic [IdBits-1:0] bid;
    bit have, stored;
    out_word_t r;
    bi = 0; bu = 1; bid = '0; have = 0; stored = 0;
    for (int k = 0; k < old_cnt; k++) begin
      box_overlap(old_boxes[k], d, i, u);
      if (i != 0) begin
        if (!have || i * bu > bi * u || (i * bu == bi * u && old_ids[k] < bid)) begin
          bi = i; bu = u; bid = old_ids[k]; have = 1;
        end
      end
    end
    r.dropped = 1'b0;
    if (have && 256 * bi > longint'(thr) * bu) begin
      r.track_id = bid;
      r.is_new = 1'b0;
    end else begin
      r.track_id = next_id;
      r.is_new = 1'b1;
      next_id = next_id + 1'b1;
    end
    for (int k = 0; k < cur_cnt; k++) begin
      if (!stored && cur_ids[k] == r.track_id) begin
        cur_boxes[k] = d;
        stored = 1;
      end
    end
    if (!stored) begin
      if (cur_cnt < MAX_TRACKS) begin
        cur_ids[cur_cnt] = r.track_id;
        cur_boxes[cur_cnt] = d;
        cur_cnt++;
      end else begin
        r.dropped = 1'b1;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      thr <= ThrReset;
      old_cnt = 0;
      cur_cnt = 0;
      next_id = '0;
      expected_ids.delete();
      fail_count <= 0;
      pending <= 0;
      matched_count <= 0;
      dropped_count <= 0;
    end else begin
      out_word_t exp_word;
      box_t d;
      if (cfg_wr_en) thr <= cfg_wr_data;
      if (in_valid && !in_stall) begin
        if (in_word.op == OP_EOF) begin
          old_ids = cur_ids;
          old_boxes = cur_boxes;
          old_cnt = cur_cnt;
          cur_cnt = 0;
        end else begin
          d.x = in_word.box_left;
          d.y = in_word.box_top;
          d.w = in_word.box_width;
          d.h = in_word.box_height;
          exp_word = assign_track(d);
          if (!exp_word.is_new) matched_count <= matched_count + 1;
          if (exp_word.dropped) dropped_count <= dropped_count + 1;
          expected_ids = {expected_ids, exp_word};
        end
      end
      if (out_valid && !out_stall) begin
        if (expected_ids.size() == 0) begin
          $display("%0t: unexpected word id=%0d new=%0b drop=%0b", $time,
                   out_word.track_id, out_word.is_new, out_word.dropped);
          fail_count <= fail_count + 1;
        end else begin
          exp_word = expected_ids.pop_front();
          if (exp_word.track_id !== out_word.track_id || exp_word.is_new !== out_word.is_new
              || exp_word.dropped !== out_word.dropped) begin
            $display("%0t: mismatch expected id=%0d new=%0b drop=%0b actual id=%0d new=%0b drop=%0b",
                     $time, exp_word.track_id, exp_word.is_new, exp_word.dropped,
                     out_word.track_id, out_word.is_new, out_word.dropped);
            fail_count <= fail_count + 1;
          end
        end
      end
      pending <= expected_ids.size();
    end
  end
endmodule

// ===== tb/tb.sv =====
// Top of the IoU track id assigner bench: clock, reset, stimulus, stall patterns, verdict.
// Depends on iou_pkg, iou_track_id_assigner and iou_checker.
`timescale 1ns / 1ps
module tb;
  import iou_pkg::*;

  localparam int unsigned MAX_TRACKS = 64;
  localparam int          CYCLE_LIMIT = 5000000;
  // Longest detection: full scan of the old table and full search of the new one.
  localparam int          DRAIN_CYCLES = 8 * MAX_TRACKS + 40;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  in_word_t   in_word;
  logic       out_valid;
  logic       out_stall;
  out_word_t  out_word;
  logic       cfg_wr_en;
  logic [7:0] cfg_wr_data;
  int         fail_count, pending, matched_count, dropped_count;
  int         cycles;
  int         sent_words;
  bit         hold_off;  // request a long receiver hold-off
  bit         stall_random;

  box_t       scene[$];  // boxes of the frame in progress, reused jittered next frame

  iou_track_id_assigner #(.MAX_TRACKS(MAX_TRACKS)) DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  iou_checker #(.MAX_TRACKS(MAX_TRACKS)) u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .fail_count(fail_count), .pending(pending),
    .matched_count(matched_count), .dropped_count(dropped_count)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Abort on a hung run.
  initial cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[iou_track_id_assigner] ERROR");
      $finish;
    end
  end

  // Receiver: stall in random phases, stall hard during a hold-off, else run free.
  initial begin
    int mode_left;
    out_stall = 1'b0;
    mode_left = 0;
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_stall <= 1'b1;
        repeat (600) @(negedge clk);
        hold_off = 1'b0;
        out_stall <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          stall_random = $urandom_range(0, 2) != 0;
          mode_left = $urandom_range(20, 300);
        end
        mode_left--;
        out_stall <= stall_random ? ($urandom_range(0, 3) == 0) : 1'b0;
      end
    end
  end

  // Offer one word and hold it until accepted; gaps between bursts are random.
  task automatic send_word(input in_word_t w);
    in_word <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_words++;
    @(negedge clk);
  endtask

  int burst_left;
  task automatic send_with_gaps(input in_word_t w);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    send_word(w);
  endtask

  task automatic send_box(input int x, input int y, input int w, input int h);
    in_word_t word;
    word.op = OP_DET;
    word.box_left = x[11:0];
    word.box_top = y[11:0];
    word.box_width = w[10:0];
    word.box_height = h[10:0];
    send_with_gaps(word);
  endtask

  task automatic end_frame();
    in_word_t word;
    logic [63:0] bits;
    bits = {$urandom(), $urandom()};
    word = bits[$bits(in_word_t)-1:0];
    word.op = OP_EOF;
    send_with_gaps(word);
  endtask

  // Drain everything, let the block go idle, then write the threshold.
  task automatic set_threshold(input logic [7:0] value);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_wr_data <= value;
    cfg_wr_en <= 1'b1;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // One frame: mostly jittered copies of the last frame's boxes, some fresh ones.
  task automatic random_frame(input int n_boxes);
    box_t prev_scene[$];
    box_t b;
    int jit;
    logic [63:0] bits;
    prev_scene = scene;
    scene.delete();
    for (int k = 0; k < n_boxes; k++) begin
      if (prev_scene.size() != 0 && $urandom_range(0, 3) != 0) begin
        b = prev_scene[$urandom_range(0, prev_scene.size() - 1)];
        jit = $urandom_range(0, 3) == 0 ? 40 : 4;
        b.x = 12'(b.x + $signed(12'($urandom_range(0, 2 * jit))) - jit);
        b.y = 12'(b.y + $signed(12'($urandom_range(0, 2 * jit))) - jit);
        b.w = 11'(b.w + $urandom_range(0, jit));
        b.h = 11'(b.h + $urandom_range(0, jit));
      end else if ($urandom_range(0, 9) == 0) begin
        bits = {$urandom(), $urandom()};
        b = bits[$bits(box_t)-1:0];
      end else begin
        b.x = 12'($urandom_range(0, 1200) - 200);
        b.y = 12'($urandom_range(0, 900) - 200);
        b.w = 11'($urandom_range(0, 300));
        b.h = 11'($urandom_range(0, 300));
      end
      scene = {scene, b};
      send_box(b.x, b.y, b.w, b.h);
    end
    end_frame();
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    hold_off = 1'b0;
    sent_words = 0;
    burst_left = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: extremes of the fields, zero-area boxes, no overlap, ties, a repeat id.
    send_box(-2048, -2048, 2047, 2047);
    send_box(2047, 2047, 2047, 2047);
    send_box(0, 0, 0, 0);
    send_box(100, 100, 0, 50);
    send_box(500, 500, 20, 20);
    send_box(520, 500, 20, 20);
    end_frame();
    send_box(-2048, -2048, 2047, 2047);  // exact match to the first box
    send_box(0, 0, 0, 0);                // zero union against a zero box
    send_box(510, 500, 20, 20);          // tie on IoU goes to lowest id; still new
    send_box(-2047, -2047, 2046, 2046);  // same id again overwrites the stored box
    send_box(1000, -1000, 5, 5);         // overlaps nothing
    end_frame();
    end_frame();                         // empty frame
    send_box(0, 0, 10, 10);

    set_threshold(8'd0);
    send_box(0, 0, 10, 10);
    end_frame();
    send_box(9, 9, 10, 10);              // tiny overlap still matches at zero threshold
    end_frame();
    set_threshold(8'd255);
    send_box(9, 9, 10, 10);              // only near-identical boxes match
    send_box(9, 9, 10, 11);
    end_frame();

    // Fill the next table past its depth so boxes get dropped.
    set_threshold(8'd128);
    for (int k = 0; k < MAX_TRACKS + 4; k++) send_box(k * 30 - 1000, 0, 10, 10);
    end_frame();

    // Receiver holds off while words keep coming in.
    hold_off = 1'b1;
    random_frame(30);

    // Random frames with the threshold stepped through a few settings.
    while (sent_words < 1680) begin
      if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 3))
          0: set_threshold(8'd0);
          1: set_threshold(8'd255);
          default: set_threshold(8'($urandom()));
        endcase
      end
      random_frame($urandom_range(0, 3) == 0 ? $urandom_range(40, 70)
                                             : $urandom_range(0, 12));
    end

    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    $display("Sent %0d words: %0d detections matched an old track, %0d dropped on a full table",
             sent_words, matched_count, dropped_count);
    $display("Thresholds 0, 128, 255 and random values; receiver hold-off and stalls exercised");
    if (fail_count == 0) begin
      $display("[iou_track_id_assigner] OK");
    end else begin
      $display("[iou_track_id_assigner] ERROR");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
hdl/iou_pkg.sv
hdl/iou_ram.sv
hdl/iou_overlap.sv
hdl/iou_track_id_assigner.sv
tb/iou_checker.sv
tb/tb.sv
